### rtl/lens_zoom_position_servo_core_macros.svh
// Assertion macros for the zoom position servo core.
// Used by the top level; expects clk and rst in scope.
`ifndef LENS_ZOOM_POSITION_SERVO_CORE_MACROS_SVH
`define LENS_ZOOM_POSITION_SERVO_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lzps_pkg.sv
// Shared types and constants for the zoom position servo core.
// No dependencies; the interfaces and modules use this package.
package lzps_pkg;

  localparam int SAMPLES_PER_PASS = 16;
  localparam int ADC_BITS         = 12;
  localparam int CNT_W            = $clog2(SAMPLES_PER_PASS);
  localparam int SUM_W            = ADC_BITS + CNT_W;
  localparam int POS_W            = 12;
  localparam int EXT_W            = POS_W + 1;
  localparam int FUNC_W           = 2;
  localparam int DRIVE_W          = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 12;
  localparam int TOL_W            = 8;
  localparam int SETTLE_W         = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CNT_W-1:0] CNT_LAST       = CNT_W'(SAMPLES_PER_PASS - 1);
  localparam logic [EXT_W-1:0] POS_HIGH_LIMIT = EXT_W'(5000);
  localparam logic [POS_W-1:0] POS_LOW_LIMIT  = POS_W'(15);

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  localparam logic [DRIVE_W-1:0] DRV_STOP = 2'd0;
  localparam logic [DRIVE_W-1:0] DRV_WIDE = 2'd1;
  localparam logic [DRIVE_W-1:0] DRV_TELE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_INC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_BAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_BAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TOL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_INT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AF_CONT     = 3'd6;

  localparam logic [POS_W-1:0]    RST_COARSE_BAND = POS_W'(100);
  localparam logic [POS_W-1:0]    RST_FINE_BAND   = POS_W'(30);
  localparam logic [TOL_W-1:0]    RST_STALL_TOL   = TOL_W'(5);
  localparam logic [POS_W-1:0]    RST_STALL_INT   = POS_W'(12'h4FF);
  localparam logic [SETTLE_W-1:0] RST_SETTLE_LIM  = SETTLE_W'(30);

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_START,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   adc;
    logic [POS_W-1:0]   target;
    logic               busy;
  } item_t;

endpackage

### rtl/lzps_if.sv
// Channel interfaces of the zoom position servo core: request, result, config.
// Widths come from lzps_pkg.
interface lzps_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lzps_pkg::FUNC_W-1:0]         func;
  logic [lzps_pkg::POS_W-1:0]          adc_sample;
  logic [lzps_pkg::POS_W-1:0]          target_position;
  logic                                pan_tilt_busy;
  modport source (output valid, func, adc_sample, target_position, pan_tilt_busy,
                  input ready);
  modport sink   (input valid, func, adc_sample, target_position, pan_tilt_busy,
                  output ready);
endinterface

interface lzps_res_if;
  logic                                valid;
  logic                                ready;
  logic [lzps_pkg::DRIVE_W-1:0]        drive;
  logic                                jog_pulse;
  logic [lzps_pkg::POS_W-1:0]          current_position;
  logic                                move_active;
  logic                                move_done;
  logic                                autofocus_reopen;
  logic                                autofocus_once;
  modport source (output valid, drive, jog_pulse, current_position, move_active,
                  move_done, autofocus_reopen, autofocus_once, input ready);
  modport sink   (input valid, drive, jog_pulse, current_position, move_active,
                  move_done, autofocus_reopen, autofocus_once, output ready);
endinterface

interface lzps_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lzps_pkg::CFG_IDX_W-1:0]      index;
  logic [lzps_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lzps_front.sv
// Front end: accepts requests, drops unused function codes, classifies the rest.
// Depends on lzps_pkg and lzps_cmd_if.
module lzps_front (
  lzps_cmd_if.sink         cmd,
  input  logic             full,
  output logic             push,
  output lzps_pkg::item_t  push_item
);
  import lzps_pkg::*;

  logic  keep;
  kind_t kind;

  always_comb begin
    keep = 1'b1;
    kind = KIND_SAMPLE;
    unique case (cmd.func)
      FUNC_SAMPLE: kind = KIND_SAMPLE;
      FUNC_START:  kind = KIND_START;
      FUNC_TICK:   kind = KIND_TICK;
      default:     keep = 1'b0;
    endcase
  end

  assign cmd.ready        = !full;
  assign push             = cmd.valid && !full && keep;
  assign push_item.kind   = kind;
  assign push_item.adc    = cmd.adc_sample & POS_W'((1 << ADC_BITS) - 1);
  assign push_item.target = cmd.target_position;
  assign push_item.busy   = cmd.pan_tilt_busy;

endmodule

### rtl/lzps_queue.sv
// Short request queue between front end and back end.
// Depends on lzps_pkg.
module lzps_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lzps_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output lzps_pkg::item_t  pop_item
);
  import lzps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_QW'(1);
        2'b01:   count <= count - CNT_QW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/lzps_back.sv
// Back end: sample averaging, pass evaluation, config registers, result register.
// Depends on lzps_pkg, lzps_cfg_if and lzps_res_if.
module lzps_back (
  input  logic             clk,
  input  logic             rst,
  lzps_cfg_if.sink         cfg,
  input  logic             q_valid,
  input  lzps_pkg::item_t  q_item,
  output logic             q_pop,
  lzps_res_if.source       result
);
  import lzps_pkg::*;

  logic                wide_inc;
  logic [POS_W-1:0]    coarse_band;
  logic [POS_W-1:0]    fine_band;
  logic [TOL_W-1:0]    stall_tol;
  logic [POS_W-1:0]    stall_int;
  logic [SETTLE_W-1:0] settle_lim;
  logic                af_cont;

  logic [SUM_W-1:0]    sample_sum, sample_sum_next;
  logic [CNT_W-1:0]    sample_count, sample_count_next;
  logic                active, active_next;
  logic [POS_W-1:0]    target, target_next;
  logic [POS_W-1:0]    stall_timer, stall_timer_next;
  logic [POS_W-1:0]    prev_pos, prev_pos_next;
  logic [SETTLE_W-1:0] settle, settle_next;
  logic                above_seen, above_seen_next;
  logic                below_seen, below_seen_next;
  logic                jog_wait, jog_wait_next;

  logic                pop;
  logic                emit;
  logic [DRIVE_W-1:0]  r_drive;
  logic                r_jog, r_done, r_afr, r_afo;

  logic [SUM_W-1:0]    sum_acc;
  logic [POS_W-1:0]    cur;
  logic [EXT_W-1:0]    cur_x, tgt_x;
  logic                out_of_range;
  logic [POS_W-1:0]    timer_inc;
  logic                stall_due;
  logic [POS_W-1:0]    pos_diff;
  logic                stalled;
  logic                hi_c, lo_c, hi_f, lo_f;
  logic [SETTLE_W-1:0] settle_inc;
  logic                settle_full;
  logic                above_n, below_n;

  function automatic logic [DRIVE_W-1:0] dir_for(input logic above, input logic swap);
    if (above) begin
      return swap ? DRV_TELE : DRV_WIDE;
    end
    return swap ? DRV_WIDE : DRV_TELE;
  endfunction

  assign cfg.ready = 1'b1;
  assign pop       = q_valid && (!result.valid || result.ready);
  assign q_pop     = pop;

  always_comb begin
    sum_acc      = sample_sum + SUM_W'(q_item.adc);
    cur          = POS_W'(sum_acc >> CNT_W);
    cur_x        = {1'b0, cur};
    tgt_x        = {1'b0, target};
    out_of_range = (cur_x > POS_HIGH_LIMIT) || (cur < POS_LOW_LIMIT);
    timer_inc    = stall_timer + POS_W'(1);
    stall_due    = (timer_inc >= stall_int);
    pos_diff     = (prev_pos >= cur) ? (prev_pos - cur) : (cur - prev_pos);
    stalled      = (pos_diff <= POS_W'(stall_tol));
    hi_c         = cur_x > (tgt_x + {1'b0, coarse_band});
    lo_c         = (cur_x + {1'b0, coarse_band}) < tgt_x;
    hi_f         = cur_x > (tgt_x + {1'b0, fine_band});
    lo_f         = (cur_x + {1'b0, fine_band}) < tgt_x;
    settle_inc   = (settle < settle_lim) ? settle + SETTLE_W'(1) : settle;
    settle_full  = (settle_inc >= settle_lim);
    above_n      = above_seen || settle_full || !lo_f;
    below_n      = below_seen || settle_full || !hi_f;
  end

  always_comb begin
    sample_sum_next   = sample_sum;
    sample_count_next = sample_count;
    active_next       = active;
    target_next       = target;
    stall_timer_next  = stall_timer;
    prev_pos_next     = prev_pos;
    settle_next       = settle;
    above_seen_next   = above_seen;
    below_seen_next   = below_seen;
    jog_wait_next     = jog_wait;
    emit              = 1'b0;
    r_drive           = DRV_STOP;
    r_jog             = 1'b0;
    r_done            = 1'b0;
    r_afr             = 1'b0;
    r_afo             = 1'b0;
    if (pop) begin
      unique case (q_item.kind)
        KIND_START: begin
          target_next       = q_item.target;
          active_next       = 1'b1;
          sample_sum_next   = '0;
          sample_count_next = '0;
        end
        KIND_TICK: begin
          jog_wait_next = 1'b0;
        end
        KIND_SAMPLE: begin
          if (active) begin
            if (sample_count != CNT_LAST) begin
              sample_sum_next   = sum_acc;
              sample_count_next = sample_count + CNT_W'(1);
            end else begin
              sample_sum_next   = '0;
              sample_count_next = '0;
              if (!(q_item.busy || out_of_range)) begin
                emit = 1'b1;
                if (stall_due) begin
                  stall_timer_next = '0;
                  if (stalled) begin
                    above_seen_next = 1'b0;
                    below_seen_next = 1'b0;
                    settle_next     = '0;
                    active_next     = 1'b0;
                    r_done          = 1'b1;
                  end else begin
                    prev_pos_next = cur;
                  end
                end else begin
                  stall_timer_next = timer_inc;
                end
                if (!(stall_due && stalled)) begin
                  if (hi_c || lo_c) begin
                    settle_next = '0;
                    r_drive     = dir_for(hi_c, wide_inc);
                  end else if (!jog_wait) begin
                    r_jog = hi_f || lo_f;
                    if (hi_f || lo_f) begin
                      r_drive       = dir_for(hi_f, wide_inc);
                      jog_wait_next = 1'b1;
                    end
                    if (above_n && below_n) begin
                      above_seen_next = 1'b0;
                      below_seen_next = 1'b0;
                      settle_next     = '0;
                      active_next     = 1'b0;
                      r_done          = 1'b1;
                      r_afr           = af_cont;
                      r_afo           = 1'b1;
                    end else begin
                      above_seen_next = above_n;
                      below_seen_next = below_n;
                      settle_next     = settle_inc;
                    end
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_inc     <= 1'b0;
      coarse_band  <= RST_COARSE_BAND;
      fine_band    <= RST_FINE_BAND;
      stall_tol    <= RST_STALL_TOL;
      stall_int    <= RST_STALL_INT;
      settle_lim   <= RST_SETTLE_LIM;
      af_cont      <= 1'b0;
      sample_sum   <= '0;
      sample_count <= '0;
      active       <= 1'b0;
      target       <= '0;
      stall_timer  <= '0;
      prev_pos     <= '0;
      settle       <= '0;
      above_seen   <= 1'b0;
      below_seen   <= 1'b0;
      jog_wait     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      sample_sum   <= sample_sum_next;
      sample_count <= sample_count_next;
      active       <= active_next;
      target       <= target_next;
      stall_timer  <= stall_timer_next;
      prev_pos     <= prev_pos_next;
      settle       <= settle_next;
      above_seen   <= above_seen_next;
      below_seen   <= below_seen_next;
      jog_wait     <= jog_wait_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_WIDE_INC:    wide_inc    <= cfg.data[0];
          CFG_COARSE_BAND: coarse_band <= cfg.data[POS_W-1:0];
          CFG_FINE_BAND:   fine_band   <= cfg.data[POS_W-1:0];
          CFG_STALL_TOL:   stall_tol   <= cfg.data[TOL_W-1:0];
          CFG_STALL_INT:   stall_int   <= cfg.data[POS_W-1:0];
          CFG_SETTLE_LIM:  settle_lim  <= cfg.data[SETTLE_W-1:0];
          CFG_AF_CONT:     af_cont     <= cfg.data[0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.drive            <= r_drive;
      result.jog_pulse        <= r_jog;
      result.current_position <= cur;
      result.move_active      <= active_next;
      result.move_done        <= r_done;
      result.autofocus_reopen <= r_afr;
      result.autofocus_once   <= r_afo;
    end
  end

endmodule

### rtl/lens_zoom_position_servo_core.sv
// Top level of the zoom position servo core: front end, queue, back end.
// Depends on lzps_pkg, lzps_if, lzps_front, lzps_queue, lzps_back and the macro header.
//
// Bang-bang zoom positioner. A start request loads a target and arms a move;
// while armed, every 16 ADC sample requests form one pass whose average is
// the current position, and each evaluated pass yields one result (skipped
// passes and start, tick and unused requests yield none). The block takes
// one request per clock while the queue is not full: the front end classifies it
// into a two-entry queue in the accepting cycle, and the back end evaluates it
// combinationally with its accumulator, band compares and stall check,
// registering the result, so a result reaches the output through the queue
// slot and the result register. Configuration writes are taken in every cycle
// and must be issued only while no request is in flight.
`include "lens_zoom_position_servo_core_macros.svh"

module lens_zoom_position_servo_core (
  input  logic       clk,
  input  logic       rst,
  lzps_cmd_if.sink   cmd,
  lzps_res_if.source result,
  lzps_cfg_if.sink   cfg
);
  import lzps_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_nonempty;
  logic  cmd_unused;
  item_t push_item;
  item_t pop_item;

  assign cmd_unused = cmd.valid && (cmd.func == FUNC_RESERVED);

  lzps_front u_front (
    .cmd       (cmd),
    .full      (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  lzps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  lzps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_nonempty),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .result  (result)
  );

  `LZPS_ASSERT_IMPLY(a_push_not_full, q_push, !q_full, "push into full queue")
  `LZPS_ASSERT_IMPLY(a_pop_not_empty, q_pop, q_nonempty, "pop from empty queue")
  `LZPS_ASSERT_IMPLY(a_unused_dropped, cmd_unused, !q_push, "unused function queued")
  `LZPS_ASSERT_NEXT(a_result_held, result.valid && !result.ready, result.valid, "result dropped")

endmodule
